@@ rtl/core/mrtd_pkg.sv @@
// mrtd_pkg: shared types and codes for the mmio range table decoder
// no dependencies; used by the interfaces, the table module, the top level and the checker
`default_nettype none

package mrtd_pkg;

  localparam int unsigned ADDR_W     = 64;
  localparam int unsigned RID_W      = 8;
  localparam int unsigned SLOT_OUT_W = 4;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned OP_W       = 2;

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP     = 2'd0,
    OP_REGISTER   = 2'd1,
    OP_UNREGISTER = 2'd2,
    OP_RESERVED   = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_OVERLAP   = 3'd2,
    ST_FULL      = 3'd3,
    ST_BAD_LEN   = 3'd4,
    ST_MISMATCH  = 3'd5,
    ST_IMMUTABLE = 3'd6
  } status_e;

  // write command into one table
  typedef struct packed {
    logic set;     // insert at the lowest free slot
    logic clr;     // remove the covering entry
    logic locked;  // immutable mark stored on insert
  } tbl_cmd_t;

  // per-table summary of the parallel compare
  typedef struct packed {
    logic cover_any;    // some valid range holds the address
    logic exact;        // covering range has same base and end
    logic locked;       // covering range is immutable
    logic overlap_any;  // [address, last] shares a byte with a valid range
    logic free_any;     // at least one free slot
  } tbl_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/mrtd_if.sv @@
// mrtd_req_if / mrtd_rsp_if: valid/ready channels of the decoder
// depends on mrtd_pkg for field widths
`default_nettype none

interface mrtd_req_if;
  logic                              valid;
  logic                              ready;
  logic [mrtd_pkg::OP_W-1:0]         operation;
  logic                              use_fallback;
  logic [mrtd_pkg::ADDR_W-1:0]       address;
  logic [mrtd_pkg::ADDR_W-1:0]       length;
  logic [mrtd_pkg::RID_W-1:0]        range_id;
  logic                              immutable;

  modport source (
    output valid, operation, use_fallback, address, length, range_id, immutable,
    input  ready
  );
  modport sink (
    input  valid, operation, use_fallback, address, length, range_id, immutable,
    output ready
  );
endinterface

interface mrtd_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [mrtd_pkg::STATUS_W-1:0]     status;
  logic                              from_fallback;
  logic [mrtd_pkg::SLOT_OUT_W-1:0]   slot;
  logic [mrtd_pkg::RID_W-1:0]        matched_id;
  logic                              hint_used;

  modport source (
    output valid, status, from_fallback, slot, matched_id, hint_used,
    input  ready
  );
  modport sink (
    input  valid, status, from_fallback, slot, matched_id, hint_used,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/core/mmio_range_table_decoder.sv @@
// mmio_range_table_decoder: primary/fallback address range tables with last-hit hint
// depends on mrtd_pkg, mrtd_req_if / mrtd_rsp_if and mrtd_table
// a taken request passes the input register and then the result register
// one transaction per cycle unless stalled; both tables compare all entries at once
// the input register stalls only while the result register holds an untaken result
// reset: clears valid bits of both tables, the hint and both pipeline valid flags
`default_nettype none

module mmio_range_table_decoder #(
  parameter int unsigned ENTRIES = 16,
  parameter int unsigned ID_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mrtd_req_if.sink    req_i,
  mrtd_rsp_if.source  rsp_o
);

  localparam int unsigned SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // ---------------------------------------------------------------
  // input register: holds the request plus its precomputed range end
  // ---------------------------------------------------------------
  logic                              in_valid_q;
  mrtd_pkg::op_e                     op_q;
  logic                              fb_q;
  logic [mrtd_pkg::ADDR_W-1:0]       addr_q;
  logic [mrtd_pkg::ADDR_W-1:0]       last_q;
  logic                              bad_len_q;
  logic [ID_BITS-1:0]                id_q;
  logic                              lock_q;

  logic                              advance;
  logic                              out_valid_q;

  logic [mrtd_pkg::ADDR_W-1:0]       len_m1;
  logic [mrtd_pkg::ADDR_W:0]         end_sum;
  logic                              bad_len_d;

  // end = base + length - 1; carry out means the range wraps
  assign len_m1    = req_i.length - 64'd1;
  assign end_sum   = {1'b0, req_i.address} + {1'b0, len_m1};
  assign bad_len_d = (req_i.length == '0) || end_sum[mrtd_pkg::ADDR_W];

  // the stage moves whenever the result register is free or being drained
  assign advance     = in_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      op_q      <= mrtd_pkg::op_e'(req_i.operation);
      fb_q      <= req_i.use_fallback;
      addr_q    <= req_i.address;
      last_q    <= end_sum[mrtd_pkg::ADDR_W-1:0];
      bad_len_q <= bad_len_d;
      id_q      <= ID_BITS'(req_i.range_id);
      lock_q    <= req_i.immutable;
    end
  end

  // ---------------------------------------------------------------
  // the two tables
  // ---------------------------------------------------------------
  mrtd_pkg::tbl_cmd_t   pri_cmd, fbk_cmd;
  mrtd_pkg::tbl_stat_t  pri_stat, fbk_stat;
  logic [ENTRIES-1:0]   pri_cover_vec, fbk_cover_vec;
  logic [SLOT_W-1:0]    pri_cover_slot, fbk_cover_slot;
  logic [SLOT_W-1:0]    pri_free_slot, fbk_free_slot;
  logic [ID_BITS-1:0]   pri_cover_ident, fbk_cover_ident;

  mrtd_table #(
    .ENTRIES (ENTRIES),
    .ID_BITS (ID_BITS)
  ) u_pri_table (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .addr_i        (addr_q),
    .last_i        (last_q),
    .cmd_i         (pri_cmd),
    .wr_ident_i    (id_q),
    .stat_o        (pri_stat),
    .cover_vec_o   (pri_cover_vec),
    .cover_slot_o  (pri_cover_slot),
    .cover_ident_o (pri_cover_ident),
    .free_slot_o   (pri_free_slot)
  );

  mrtd_table #(
    .ENTRIES (ENTRIES),
    .ID_BITS (ID_BITS)
  ) u_fbk_table (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .addr_i        (addr_q),
    .last_i        (last_q),
    .cmd_i         (fbk_cmd),
    .wr_ident_i    (id_q),
    .stat_o        (fbk_stat),
    .cover_vec_o   (fbk_cover_vec),
    .cover_slot_o  (fbk_cover_slot),
    .cover_ident_o (fbk_cover_ident),
    .free_slot_o   (fbk_free_slot)
  );

  // fallback cover vector is only summarized inside the table; keep a use for the
  // fallback lookup path as an explicit hit flag
  logic fbk_hit;
  assign fbk_hit = |fbk_cover_vec;

  // ---------------------------------------------------------------
  // last-hit hint (primary table only)
  // ---------------------------------------------------------------
  logic               hint_valid_q;
  logic [SLOT_W-1:0]  hint_slot_q;
  logic               hint_hit;
  logic               hint_set;
  logic               hint_clr;

  // primary ranges never overlap, so a hint hit is the same entry as the
  // primary search result; only hint_used differs
  assign hint_hit = hint_valid_q && pri_cover_vec[hint_slot_q];

  // ---------------------------------------------------------------
  // decision logic
  // ---------------------------------------------------------------
  mrtd_pkg::tbl_stat_t          tgt_stat;
  logic [SLOT_W-1:0]            tgt_cover_slot;
  logic [SLOT_W-1:0]            tgt_free_slot;
  logic [ID_BITS-1:0]           tgt_cover_ident;
  logic                         ident_eq;
  logic                         do_set;
  logic                         do_clr;

  mrtd_pkg::status_e            status_d;
  logic                         from_fb_d;
  logic [mrtd_pkg::SLOT_OUT_W-1:0] slot_d;
  logic [mrtd_pkg::RID_W-1:0]   matched_id_d;
  logic                         hint_used_d;

  // register/unregister act on the table chosen by use_fallback
  assign tgt_stat        = fb_q ? fbk_stat : pri_stat;
  assign tgt_cover_slot  = fb_q ? fbk_cover_slot : pri_cover_slot;
  assign tgt_free_slot   = fb_q ? fbk_free_slot : pri_free_slot;
  assign tgt_cover_ident = fb_q ? fbk_cover_ident : pri_cover_ident;
  assign ident_eq        = (tgt_cover_ident == id_q);

  always_comb begin
    status_d     = mrtd_pkg::ST_NOT_FOUND;
    from_fb_d    = 1'b0;
    slot_d       = '0;
    matched_id_d = '0;
    hint_used_d  = 1'b0;
    do_set       = 1'b0;
    do_clr       = 1'b0;
    hint_set     = 1'b0;
    hint_clr     = 1'b0;
    unique case (op_q)
      mrtd_pkg::OP_LOOKUP: begin
        // primary first (hint included), then fallback
        if (pri_stat.cover_any) begin
          status_d     = mrtd_pkg::ST_OK;
          slot_d       = mrtd_pkg::SLOT_OUT_W'(pri_cover_slot);
          matched_id_d = mrtd_pkg::RID_W'(pri_cover_ident);
          hint_used_d  = hint_hit;
          hint_set     = !hint_hit;
        end else if (fbk_hit) begin
          status_d     = mrtd_pkg::ST_OK;
          from_fb_d    = 1'b1;
          slot_d       = mrtd_pkg::SLOT_OUT_W'(fbk_cover_slot);
          matched_id_d = mrtd_pkg::RID_W'(fbk_cover_ident);
        end
      end
      mrtd_pkg::OP_REGISTER: begin
        from_fb_d = fb_q;
        // zero length or wrap, then overlap, then full table
        if (bad_len_q) begin
          status_d = mrtd_pkg::ST_BAD_LEN;
        end else if (tgt_stat.overlap_any) begin
          status_d = mrtd_pkg::ST_OVERLAP;
        end else if (!tgt_stat.free_any) begin
          status_d = mrtd_pkg::ST_FULL;
        end else begin
          status_d = mrtd_pkg::ST_OK;
          slot_d   = mrtd_pkg::SLOT_OUT_W'(tgt_free_slot);
          do_set   = 1'b1;
        end
      end
      mrtd_pkg::OP_UNREGISTER: begin
        from_fb_d = fb_q;
        if (tgt_stat.cover_any) begin
          slot_d = mrtd_pkg::SLOT_OUT_W'(tgt_cover_slot);
          // mismatch wins over immutable
          if (!(tgt_stat.exact && ident_eq)) begin
            status_d = mrtd_pkg::ST_MISMATCH;
          end else if (tgt_stat.locked) begin
            status_d = mrtd_pkg::ST_IMMUTABLE;
          end else begin
            status_d = mrtd_pkg::ST_OK;
            do_clr   = 1'b1;
            // removing the hinted primary entry drops the hint
            hint_clr = !fb_q && hint_valid_q && (hint_slot_q == pri_cover_slot);
          end
        end
      end
      mrtd_pkg::OP_RESERVED: begin
        // unused code: not found, everything else zero
        status_d = mrtd_pkg::ST_NOT_FOUND;
      end
      default: begin
        status_d = mrtd_pkg::ST_NOT_FOUND;
      end
    endcase
  end

  // table writes only when the transaction leaves the input register
  always_comb begin
    pri_cmd.set    = advance && do_set && !fb_q;
    pri_cmd.clr    = advance && do_clr && !fb_q;
    pri_cmd.locked = lock_q;
    fbk_cmd.set    = advance && do_set && fb_q;
    fbk_cmd.clr    = advance && do_clr && fb_q;
    fbk_cmd.locked = lock_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hint_valid_q <= 1'b0;
      hint_slot_q  <= '0;
    end else if (advance) begin
      if (hint_set) begin
        hint_valid_q <= 1'b1;
        hint_slot_q  <= pri_cover_slot;
      end else if (hint_clr) begin
        hint_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------
  mrtd_pkg::status_e               status_q;
  logic                            from_fb_q;
  logic [mrtd_pkg::SLOT_OUT_W-1:0] slot_q;
  logic [mrtd_pkg::RID_W-1:0]      matched_id_q;
  logic                            hint_used_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      status_q     <= status_d;
      from_fb_q    <= from_fb_d;
      slot_q       <= slot_d;
      matched_id_q <= matched_id_d;
      hint_used_q  <= hint_used_d;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = status_q;
  assign rsp_o.from_fallback = from_fb_q;
  assign rsp_o.slot          = slot_q;
  assign rsp_o.matched_id    = matched_id_q;
  assign rsp_o.hint_used     = hint_used_q;

endmodule

`default_nettype wire

@@ rtl/core/mrtd_table.sv @@
// mrtd_table: one range table with parallel cover and overlap compare per entry
// depends on mrtd_pkg (tbl_cmd_t, tbl_stat_t, ADDR_W)
`default_nettype none

module mrtd_table #(
  parameter int unsigned ENTRIES = 16,
  parameter int unsigned ID_BITS = 8,
  localparam int unsigned SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [mrtd_pkg::ADDR_W-1:0]   addr_i,
  input  logic [mrtd_pkg::ADDR_W-1:0]   last_i,
  input  mrtd_pkg::tbl_cmd_t            cmd_i,
  input  logic [ID_BITS-1:0]            wr_ident_i,
  output mrtd_pkg::tbl_stat_t           stat_o,
  output logic [ENTRIES-1:0]            cover_vec_o,
  output logic [SLOT_W-1:0]             cover_slot_o,
  output logic [ID_BITS-1:0]            cover_ident_o,
  output logic [SLOT_W-1:0]             free_slot_o
);

  logic [ENTRIES-1:0]              valid_q;
  logic [ENTRIES-1:0]              locked_q;
  logic [mrtd_pkg::ADDR_W-1:0]     base_q  [ENTRIES];
  logic [mrtd_pkg::ADDR_W-1:0]     end_q   [ENTRIES];
  logic [ID_BITS-1:0]              ident_q [ENTRIES];

  logic [ENTRIES-1:0]              cover_vec;
  logic [ENTRIES-1:0]              ovl_vec;
  logic [ENTRIES-1:0]              free_vec;
  logic [ENTRIES-1:0]              cover_oh;
  logic [ENTRIES-1:0]              free_oh;
  logic [mrtd_pkg::ADDR_W-1:0]     sel_base;
  logic [mrtd_pkg::ADDR_W-1:0]     sel_end;
  logic [ID_BITS-1:0]              sel_ident;
  logic                            sel_locked;
  logic [SLOT_W-1:0]               cover_slot;
  logic [SLOT_W-1:0]               free_slot;

  // per-entry compares, all in parallel
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      cover_vec[i] = valid_q[i] && (addr_i >= base_q[i]) && (addr_i <= end_q[i]);
      ovl_vec[i]   = valid_q[i] && !((last_i < base_q[i]) || (addr_i > end_q[i]));
    end
  end

  assign free_vec = ~valid_q;
  // isolate lowest set bit
  assign cover_oh = cover_vec & (~cover_vec + 1'b1);
  assign free_oh  = free_vec & (~free_vec + 1'b1);

  // one-hot and-or selection of the covering entry and free slot
  always_comb begin
    sel_base   = '0;
    sel_end    = '0;
    sel_ident  = '0;
    sel_locked = 1'b0;
    cover_slot = '0;
    free_slot  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (cover_oh[i]) begin
        sel_base   = sel_base | base_q[i];
        sel_end    = sel_end | end_q[i];
        sel_ident  = sel_ident | ident_q[i];
        sel_locked = sel_locked | locked_q[i];
        cover_slot = cover_slot | SLOT_W'(i);
      end
      if (free_oh[i]) begin
        free_slot = free_slot | SLOT_W'(i);
      end
    end
  end

  always_comb begin
    stat_o.cover_any   = |cover_vec;
    stat_o.exact       = (sel_base == addr_i) && (sel_end == last_i);
    stat_o.locked      = sel_locked;
    stat_o.overlap_any = |ovl_vec;
    stat_o.free_any    = |free_vec;
  end

  assign cover_vec_o   = cover_vec;
  assign cover_slot_o  = cover_slot;
  assign cover_ident_o = sel_ident;
  assign free_slot_o   = free_slot;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.set) begin
      valid_q[free_slot] <= 1'b1;
    end else if (cmd_i.clr) begin
      valid_q[cover_slot] <= 1'b0;
    end
  end

  // entry payload, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.set) begin
      base_q[free_slot]   <= addr_i;
      end_q[free_slot]    <= last_i;
      ident_q[free_slot]  <= wr_ident_i;
      locked_q[free_slot] <= cmd_i.locked;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/mrtd_checker.sv @@
// mrtd_checker: port-level assertions for the mmio range table decoder
// depends on mrtd_pkg; bound to mmio_range_table_decoder below
`default_nettype none

module mrtd_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              req_ready_i,
  input  logic                              rsp_valid_i,
  input  logic                              rsp_ready_i,
  input  logic [mrtd_pkg::STATUS_W-1:0]     status_i,
  input  logic                              from_fallback_i,
  input  logic [mrtd_pkg::SLOT_OUT_W-1:0]   slot_i,
  input  logic [mrtd_pkg::RID_W-1:0]        matched_id_i,
  input  logic                              hint_used_i
);

  // a pending result stays until taken
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result dropped before it was taken");

  // a stalled result keeps its payload
  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> $stable(status_i) && $stable(from_fallback_i)
      && $stable(slot_i) && $stable(matched_id_i) && $stable(hint_used_i))
    else $error("stalled result changed");

  // an empty result register never blocks the request side
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rsp_valid_i |-> req_ready_i)
    else $error("request stalled with empty result register");

  // a hint hit is always a successful primary lookup
  a_hint_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && hint_used_i |-> (status_i == mrtd_pkg::ST_OK) && !from_fallback_i)
    else $error("hint used on a result that is not a primary hit");

  // failed transactions carry no matched id or hint
  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i != mrtd_pkg::ST_OK) |-> !hint_used_i && (matched_id_i == '0))
    else $error("failed transaction reports a match");

endmodule

bind mmio_range_table_decoder mrtd_checker u_mrtd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_ready_i     (req_i.ready),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .status_i        (rsp_o.status),
  .from_fallback_i (rsp_o.from_fallback),
  .slot_i          (rsp_o.slot),
  .matched_id_i    (rsp_o.matched_id),
  .hint_used_i     (rsp_o.hint_used)
);

`default_nettype wire

@@ test/mrtd_decode_checker.sv @@
`timescale 1ns / 1ps
// mrtd_decode_checker: watches both channels of the range table decoder and predicts every result
// depends on mrtd_pkg and the mrtd_req_if / mrtd_rsp_if interfaces

module mrtd_decode_checker
  import mrtd_pkg::*;
#(
  parameter int unsigned ENTRIES = 16,
  parameter int unsigned ID_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mrtd_req_if         req_mon_i,
  mrtd_rsp_if         rsp_mon_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned checked_o
);

  localparam int unsigned SLOTS = 2 * ENTRIES;
  localparam logic [RID_W-1:0] ID_MASK = RID_W'((32'd1 << ID_BITS) - 32'd1);

  typedef struct packed {
    status_e               status;
    logic                  from_fallback;
    logic [SLOT_OUT_W-1:0] slot;
    logic [RID_W-1:0]      matched_id;
    logic                  hint_used;
  } decode_result_t;

  // slots 0..ENTRIES-1 primary, ENTRIES..SLOTS-1 fallback
  logic              range_valid  [SLOTS];
  logic [ADDR_W-1:0] range_base   [SLOTS];
  logic [ADDR_W-1:0] range_last   [SLOTS];
  logic [RID_W-1:0]  range_id     [SLOTS];
  logic              range_locked [SLOTS];
  logic              hint_valid;
  int                hint_slot;
  decode_result_t    expected_q [$];
  int unsigned       mismatches;
  int unsigned       checked;

  function automatic logic holds(int unsigned k, logic [ADDR_W-1:0] addr);
    return range_valid[k] && addr >= range_base[k] && addr <= range_last[k];
  endfunction

  // slot within the table whose range holds addr, or -1
  function automatic int find_holder(int unsigned tbl, logic [ADDR_W-1:0] addr);
    int i;
    for (i = 0; i < ENTRIES; i++) begin
      if (holds(tbl * ENTRIES + i, addr)) return i;
    end
    return -1;
  endfunction

  function automatic decode_result_t predict_decode(op_e op, logic tbl,
                                                    logic [ADDR_W-1:0] addr,
                                                    logic [ADDR_W-1:0] len,
                                                    logic [RID_W-1:0] rid, logic imm);
    decode_result_t    res;
    logic [ADDR_W-1:0] last;
    logic [RID_W-1:0]  id;
    int unsigned       off;
    int unsigned       k;
    int                hit;
    int                free_slot;
    int                i;
    res = '0;
    id = rid & ID_MASK;
    off = tbl ? ENTRIES : 0;
    case (op)
      OP_LOOKUP: begin
        hit = find_holder(0, addr);
        if (hint_valid && holds(hint_slot, addr)) begin
          res.slot = SLOT_OUT_W'(hint_slot);
          res.matched_id = range_id[hint_slot];
          res.hint_used = 1'b1;
        end else if (hit >= 0) begin
          hint_valid = 1'b1;
          hint_slot = hit;
          res.slot = SLOT_OUT_W'(hit);
          res.matched_id = range_id[hit];
        end else begin
          hit = find_holder(1, addr);
          if (hit >= 0) begin
            res.from_fallback = 1'b1;
            res.slot = SLOT_OUT_W'(hit);
            res.matched_id = range_id[ENTRIES + hit];
          end else begin
            res.status = ST_NOT_FOUND;
          end
        end
      end
      OP_REGISTER: begin
        res.from_fallback = tbl;
        last = addr + len - 1;
        free_slot = -1;
        if (len == '0 || last < addr) begin
          res.status = ST_BAD_LEN;
        end else begin
          for (i = 0; i < ENTRIES; i++) begin
            k = off + i;
            if (range_valid[k]) begin
              if (!(last < range_base[k] || addr > range_last[k])) res.status = ST_OVERLAP;
            end else if (free_slot < 0) begin
              free_slot = i;
            end
          end
          // overlap wins over a full table
          if (res.status == ST_OK) begin
            if (free_slot < 0) begin
              res.status = ST_FULL;
            end else begin
              k = off + free_slot;
              range_valid[k] = 1'b1;
              range_base[k] = addr;
              range_last[k] = last;
              range_id[k] = id;
              range_locked[k] = imm;
              res.slot = SLOT_OUT_W'(free_slot);
            end
          end
        end
      end
      OP_UNREGISTER: begin
        res.from_fallback = tbl;
        hit = find_holder(tbl, addr);
        if (hit < 0) begin
          res.status = ST_NOT_FOUND;
        end else begin
          k = off + hit;
          res.slot = SLOT_OUT_W'(hit);
          if (range_id[k] != id || range_base[k] != addr ||
              range_last[k] - range_base[k] + 1 != len) begin
            res.status = ST_MISMATCH;
          end else if (range_locked[k]) begin
            res.status = ST_IMMUTABLE;
          end else begin
            range_valid[k] = 1'b0;
            if (!tbl && hint_valid && hint_slot == hit) hint_valid = 1'b0;
          end
        end
      end
      default: res.status = ST_NOT_FOUND;
    endcase
    return res;
  endfunction

  function automatic int unsigned field_diff(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("time %0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    decode_result_t want;
    int i;
    if (!rst_ni) begin
      for (i = 0; i < SLOTS; i++) begin
        range_valid[i] = 1'b0;
        range_base[i] = '0;
        range_last[i] = '0;
        range_id[i] = '0;
        range_locked[i] = 1'b0;
      end
      hint_valid = 1'b0;
      hint_slot = 0;
      expected_q.delete();
      mismatches = 0;
      checked = 0;
      fail_count_o <= 0;
      pending_o <= 0;
      checked_o <= 0;
    end else begin
      // results first: a result never belongs to a request taken at the same edge
      if (rsp_mon_i.valid && rsp_mon_i.ready) begin
        checked++;
        if (expected_q.size() == 0) begin
          $display("time %0t: unexpected result, expected none, actual status %0d",
                   $time, rsp_mon_i.status);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          mismatches += field_diff("status", 8'(want.status), 8'(rsp_mon_i.status));
          mismatches += field_diff("from_fallback", 8'(want.from_fallback),
                                   8'(rsp_mon_i.from_fallback));
          mismatches += field_diff("slot", 8'(want.slot), 8'(rsp_mon_i.slot));
          mismatches += field_diff("matched_id", 8'(want.matched_id),
                                   8'(rsp_mon_i.matched_id));
          mismatches += field_diff("hint_used", 8'(want.hint_used), 8'(rsp_mon_i.hint_used));
        end
      end
      if (req_mon_i.valid && req_mon_i.ready) begin
        expected_q.push_back(predict_decode(op_e'(req_mon_i.operation), req_mon_i.use_fallback,
                                            req_mon_i.address, req_mon_i.length,
                                            req_mon_i.range_id, req_mon_i.immutable));
      end
      fail_count_o <= mismatches;
      pending_o <= expected_q.size();
      checked_o <= checked;
    end
  end

endmodule

@@ test/tb_mmio_range_table_decoder.sv @@
`timescale 1ns / 1ps
// tb_mmio_range_table_decoder: stimulus and verdict for the mmio range table decoder
// depends on mrtd_pkg, mrtd_req_if / mrtd_rsp_if, the decoder rtl and mrtd_decode_checker

module tb_mmio_range_table_decoder;
  import mrtd_pkg::*;

  localparam int unsigned ENTRIES      = 16;
  localparam int unsigned ID_BITS      = 8;
  localparam int unsigned ITEM_GOAL    = 1100;   // random part stops past this many transactions
  localparam int unsigned PHASE_ITEMS  = 100;    // random transactions per address window
  localparam int unsigned PLACED_MAX   = 128;    // register attempts remembered for reuse
  localparam int unsigned DRAIN_CYCLES = 8;      // quiet cycles after the last result
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam logic [ADDR_W-1:0] ALL_ONES = '1;

  // one request transaction as the stimulus sees it
  typedef struct {
    op_e               op;
    logic              fb;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] len;
    logic [RID_W-1:0]  rid;
    logic              imm;
  } decode_req_t;

  logic clk_i   = 1'b0;
  logic rst_ni  = 1'b0;
  logic no_idle = 1'b0;   // high for one whole window: neither side idles

  int unsigned cycle_count = 0;
  int unsigned sent = 0;
  int unsigned op_count [4] = '{default: 0};
  int unsigned windows = 0;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;

  // stimulus bookkeeping: current address window, earlier register attempts,
  // how many immutable ranges each table may still receive
  logic [ADDR_W-1:0] win_base = '0;
  logic [ADDR_W-1:0] last_lookup = '0;
  decode_req_t       placed_q [$];
  int unsigned       locks_left [2] = '{3, 4};

  mrtd_req_if req_if ();
  mrtd_rsp_if rsp_if ();

  mmio_range_table_decoder #(
    .ENTRIES (ENTRIES),
    .ID_BITS (ID_BITS)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  mrtd_decode_checker #(
    .ENTRIES (ENTRIES),
    .ID_BITS (ID_BITS)
  ) u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_mon_i    (req_if),
    .rsp_mon_i    (rsp_if),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always #5 clk_i = ~clk_i;

  // result side: stalls in about a quarter of the cycles unless the quiet window is on
  always @(posedge clk_i) begin
    rsp_if.ready <= no_idle || ($urandom_range(99) >= 25);
  end

  // hard stop in case the block hangs or drops a result
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [ADDR_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic decode_req_t make_req(op_e op, logic fb, logic [ADDR_W-1:0] addr,
                                           logic [ADDR_W-1:0] len, logic [RID_W-1:0] rid,
                                           logic imm);
    decode_req_t it;
    it.op = op;
    it.fb = fb;
    it.addr = addr;
    it.len = len;
    it.rid = rid;
    it.imm = imm;
    return it;
  endfunction

  // register inside the current window; dense windows use tiny ranges so the tables fill up
  function automatic decode_req_t make_register(logic dense);
    decode_req_t it;
    int unsigned roll;
    it.op = OP_REGISTER;
    it.fb = 1'($urandom_range(1));
    roll = $urandom_range(9);
    if (dense) begin
      it.addr = win_base + $urandom_range(255);
      it.len = $urandom_range(8, 1);
    end else begin
      it.addr = win_base + $urandom_range(4095);
      it.len = (roll < 7) ? $urandom_range(256, 1) : (roll < 9) ? 1 : $urandom_range(8192, 257);
    end
    it.rid = RID_W'($urandom);
    it.imm = 1'b0;
    // immutable ranges never go away, so only a few are allowed per table
    if (locks_left[it.fb] != 0 && $urandom_range(19) == 0) begin
      it.imm = 1'b1;
      locks_left[it.fb]--;
    end
    placed_q.push_back(it);
    if (placed_q.size() > PLACED_MAX) void'(placed_q.pop_front());
    return it;
  endfunction

  // lookups aim at known ranges at their edges or inside about half the time; repeats exercise the hint
  function automatic decode_req_t make_lookup();
    decode_req_t       p;
    logic [ADDR_W-1:0] a;
    int unsigned       roll;
    roll = $urandom_range(99);
    if (roll < 50 && placed_q.size() != 0) begin
      p = placed_q[$urandom_range(placed_q.size() - 1)];
      case ($urandom_range(2))
        0: a = p.addr;
        1: a = p.addr + p.len - 1;
        default: a = p.addr + rand64() % p.len;
      endcase
    end else if (roll < 65) begin
      a = last_lookup;
    end else if (roll < 88) begin
      a = win_base + $urandom_range(4095);
    end else begin
      a = rand64();
    end
    last_lookup = a;
    return make_req(OP_LOOKUP, 1'($urandom_range(1)), a, rand64(), RID_W'($urandom),
                    1'($urandom_range(1)));
  endfunction

  // exact removal of an earlier attempt half the time, otherwise one field is off
  function automatic decode_req_t make_unregister();
    decode_req_t it;
    int unsigned idx;
    if (placed_q.size() == 0) begin
      return make_req(OP_UNREGISTER, 1'($urandom_range(1)), win_base + $urandom_range(4095),
                      $urandom_range(256, 1), RID_W'($urandom), 1'($urandom_range(1)));
    end
    idx = $urandom_range(placed_q.size() - 1);
    it = placed_q[idx];
    it.op = OP_UNREGISTER;
    it.imm = 1'($urandom_range(1));
    case ($urandom_range(9))
      0: it.rid ^= RID_W'(1) << $urandom_range(RID_W - 1);
      1: it.len += 1;
      2: it.len -= 1;
      3: it.addr += 1;
      4: it.fb = !it.fb;
      default: placed_q.delete(idx);
    endcase
    return it;
  endfunction

  // noise: reserved code, wrapping registers with random upper bits, wild addresses
  function automatic decode_req_t make_noise();
    case ($urandom_range(3))
      0: return make_req(OP_RESERVED, 1'($urandom_range(1)), rand64(), rand64(),
                         RID_W'($urandom), 1'($urandom_range(1)));
      1: return make_req(OP_REGISTER, 1'($urandom_range(1)), rand64() | 64'h8000_0000_0000_0001,
                         rand64() | 64'h8000_0000_0000_0000, RID_W'($urandom),
                         1'($urandom_range(1)));
      2: return make_req(OP_LOOKUP, 1'($urandom_range(1)), rand64(), rand64(),
                         RID_W'($urandom), 1'($urandom_range(1)));
      default: return make_req(OP_UNREGISTER, 1'($urandom_range(1)), rand64(), rand64(),
                               RID_W'($urandom), 1'($urandom_range(1)));
    endcase
  endfunction

  // called at a rising edge; returns at the edge where the transaction is taken
  task automatic drive_request(input decode_req_t it);
    if (!no_idle && $urandom_range(99) < 25) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(2, 1)) @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.operation    <= it.op;
    req_if.use_fallback <= it.fb;
    req_if.address      <= it.addr;
    req_if.length       <= it.len;
    req_if.range_id     <= it.rid;
    req_if.immutable    <= it.imm;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sent++;
    op_count[it.op]++;
  endtask

  initial begin
    decode_req_t it;
    logic        dense;
    int unsigned roll;
    int unsigned phase;

    req_if.valid        <= 1'b0;
    req_if.operation    <= OP_LOOKUP;
    req_if.use_fallback <= 1'b0;
    req_if.address      <= '0;
    req_if.length       <= '0;
    req_if.range_id     <= '0;
    req_if.immutable    <= 1'b0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part: corner cases one by one
    // lookup in empty tables misses
    drive_request(make_req(OP_LOOKUP, 1'b0, '0, '0, 8'h00, 1'b0));
    // zero length and a range running past the top of the address space are bad lengths
    drive_request(make_req(OP_REGISTER, 1'b0, 64'h1000, '0, 8'h11, 1'b0));
    drive_request(make_req(OP_REGISTER, 1'b0, ALL_ONES, 64'd2, 8'h22, 1'b0));
    // last byte of the address space, locked: primary slot 0
    drive_request(make_req(OP_REGISTER, 1'b0, ALL_ONES, 64'd1, 8'hFF, 1'b1));
    // [0, 15] in primary slot 1
    drive_request(make_req(OP_REGISTER, 1'b0, '0, 64'd16, 8'h00, 1'b0));
    // base inside an existing range, and a range covering almost everything: overlap
    drive_request(make_req(OP_REGISTER, 1'b0, 64'd8, 64'd4, 8'h33, 1'b0));
    drive_request(make_req(OP_REGISTER, 1'b0, '0, ALL_ONES, 8'h44, 1'b0));
    // same bytes in the fallback table are fine: [0, 31]
    drive_request(make_req(OP_REGISTER, 1'b1, '0, 64'd32, 8'hA5, 1'b0));
    // primary hit sets the hint, next lookup in that range uses it (use_fallback ignored)
    drive_request(make_req(OP_LOOKUP, 1'b0, '0, '0, 8'h00, 1'b0));
    drive_request(make_req(OP_LOOKUP, 1'b1, 64'd15, '0, 8'h00, 1'b0));
    // primary misses, fallback hits
    drive_request(make_req(OP_LOOKUP, 1'b0, 64'd16, '0, 8'h00, 1'b0));
    // top address hits primary slot 0 and moves the hint there
    drive_request(make_req(OP_LOOKUP, 1'b0, ALL_ONES, '0, 8'h00, 1'b0));
    // locked range cannot be removed; a wrong length reports mismatch before the lock
    drive_request(make_req(OP_UNREGISTER, 1'b0, ALL_ONES, 64'd1, 8'hFF, 1'b0));
    drive_request(make_req(OP_UNREGISTER, 1'b0, ALL_ONES, 64'd2, 8'hFF, 1'b0));
    // wrong id, wrong length, base inside but not equal: mismatch, nothing removed
    drive_request(make_req(OP_UNREGISTER, 1'b0, '0, 64'd16, 8'h01, 1'b0));
    drive_request(make_req(OP_UNREGISTER, 1'b0, '0, 64'd15, 8'h00, 1'b0));
    drive_request(make_req(OP_UNREGISTER, 1'b0, 64'd4, 64'd12, 8'h00, 1'b0));
    // address held by nothing
    drive_request(make_req(OP_UNREGISTER, 1'b0, 64'd100, 64'd16, 8'h00, 1'b0));
    // hint back on slot 1, then removing slot 1 clears it; the next lookup falls through
    drive_request(make_req(OP_LOOKUP, 1'b0, 64'd5, '0, 8'h00, 1'b0));
    drive_request(make_req(OP_UNREGISTER, 1'b0, '0, 64'd16, 8'h00, 1'b0));
    drive_request(make_req(OP_LOOKUP, 1'b0, 64'd5, '0, 8'h00, 1'b0));
    // reserved operation code
    drive_request(make_req(OP_RESERVED, 1'b1, rand64(), rand64(), 8'hFF, 1'b1));
    // clean fallback removal
    drive_request(make_req(OP_UNREGISTER, 1'b1, '0, 64'd32, 8'hA5, 1'b0));

    // random part: one address window per phase; every third window is dense and
    // register heavy so both tables run full; the window of phase four runs with no idling at all
    phase = 0;
    while (sent < ITEM_GOAL) begin
      dense = (phase % 3 == 0);
      no_idle <= (phase == 4);
      win_base = rand64() & ~64'hFFFF;
      windows++;
      repeat (PHASE_ITEMS) begin
        roll = $urandom_range(99);
        if (dense) begin
          if (roll < 60) it = make_register(1'b1);
          else if (roll < 88) it = make_lookup();
          else if (roll < 95) it = make_unregister();
          else it = make_noise();
        end else begin
          if (roll < 35) it = make_lookup();
          else if (roll < 65) it = make_register(1'b0);
          else if (roll < 90) it = make_unregister();
          else it = make_noise();
        end
        drive_request(it);
      end
      // tear the window down so the next one starts with free slots
      while (placed_q.size() != 0) begin
        it = placed_q.pop_front();
        it.op = OP_UNREGISTER;
        drive_request(it);
      end
      phase++;
    end
    no_idle <= 1'b0;

    // drain: the pending count is registered, so step before polling
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run covered %0d transactions: %0d lookups, %0d registers, %0d unregisters,",
             sent, op_count[OP_LOOKUP], op_count[OP_REGISTER], op_count[OP_UNREGISTER]);
    $display("%0d reserved; %0d results compared over %0d address windows, %0d field mismatches",
             op_count[OP_RESERVED], checked, windows, fail_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
